### src/ps2_scancode_to_ascii_assert.svh
// Assertion macros for the scancode decoder checker.
// Both expect clk and arst_n in scope.
`ifndef PS2_SCANCODE_TO_ASCII_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_ASSERT_SVH

// cond in one cycle implies resp in the same cycle
`define PS2SA_CHECK(lbl, cond, resp) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (resp)) \
		else $error("ps2sa: same-cycle check failed");

// cond in one cycle implies resp in the next
`define PS2SA_NEXT(lbl, cond, resp) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (resp)) \
		else $error("ps2sa: next-cycle check failed");

`endif

### src/ps2sa_pkg.sv
package ps2sa_pkg;

	localparam logic [7:0] ESC_PREFIX = 8'hE0;

	localparam int unsigned MOD_SHIFT  = 0;
	localparam int unsigned MOD_CTRL   = 1;
	localparam int unsigned MOD_ALT    = 2;
	localparam int unsigned MOD_CAPS   = 3;
	localparam int unsigned MOD_NUM    = 4;
	localparam int unsigned MOD_SCROLL = 5;

	typedef logic [5:0] mod_t;

	localparam logic [7:0] K_HOME = 8'hE0;
	localparam logic [7:0] K_END  = 8'hE1;
	localparam logic [7:0] K_UP   = 8'hE2;
	localparam logic [7:0] K_DN   = 8'hE3;
	localparam logic [7:0] K_LF   = 8'hE4;
	localparam logic [7:0] K_RT   = 8'hE5;
	localparam logic [7:0] K_PGUP = 8'hE6;
	localparam logic [7:0] K_PGDN = 8'hE7;
	localparam logic [7:0] K_INS  = 8'hE8;
	localparam logic [7:0] K_DEL  = 8'hE9;

	// extended (prefixed) navigation keys, shared by all three maps
	function automatic logic [7:0] ext_lut(input logic [7:0] code);
		case (code)
			8'hC7: ext_lut = K_HOME;
			8'hC8: ext_lut = K_UP;
			8'hC9: ext_lut = K_PGUP;
			8'hCB: ext_lut = K_LF;
			8'hCD: ext_lut = K_RT;
			8'hCF: ext_lut = K_END;
			8'hD0: ext_lut = K_DN;
			8'hD1: ext_lut = K_PGDN;
			8'hD2: ext_lut = K_INS;
			8'hD3: ext_lut = K_DEL;
			default: ext_lut = 8'h00;
		endcase
	endfunction

	// keypad block, same in plain and shifted maps
	function automatic logic [7:0] pad_lut(input logic [7:0] code);
		case (code)
			8'h37: pad_lut = "*";
			8'h39: pad_lut = " ";
			8'h47: pad_lut = "7";
			8'h48: pad_lut = "8";
			8'h49: pad_lut = "9";
			8'h4A: pad_lut = "-";
			8'h4B: pad_lut = "4";
			8'h4C: pad_lut = "5";
			8'h4D: pad_lut = "6";
			8'h4E: pad_lut = "+";
			8'h4F: pad_lut = "1";
			8'h50: pad_lut = "2";
			8'h51: pad_lut = "3";
			8'h52: pad_lut = "0";
			8'h53: pad_lut = ".";
			8'h01: pad_lut = 8'h1B;
			8'h0E: pad_lut = 8'h08;
			8'h0F: pad_lut = 8'h09;
			8'h1C: pad_lut = 8'h0A;
			8'h9C: pad_lut = 8'h0A;
			8'hB5: pad_lut = "/";
			default: pad_lut = ext_lut(code);
		endcase
	endfunction

	function automatic logic [7:0] plain_lut(input logic [7:0] code);
		case (code)
			8'h02: plain_lut = "1";
			8'h03: plain_lut = "2";
			8'h04: plain_lut = "3";
			8'h05: plain_lut = "4";
			8'h06: plain_lut = "5";
			8'h07: plain_lut = "6";
			8'h08: plain_lut = "7";
			8'h09: plain_lut = "8";
			8'h0A: plain_lut = "9";
			8'h0B: plain_lut = "0";
			8'h0C: plain_lut = "-";
			8'h0D: plain_lut = "=";
			8'h10: plain_lut = "q";
			8'h11: plain_lut = "w";
			8'h12: plain_lut = "e";
			8'h13: plain_lut = "r";
			8'h14: plain_lut = "t";
			8'h15: plain_lut = "y";
			8'h16: plain_lut = "u";
			8'h17: plain_lut = "i";
			8'h18: plain_lut = "o";
			8'h19: plain_lut = "p";
			8'h1A: plain_lut = 8'h5B;
			8'h1B: plain_lut = 8'h5D;
			8'h1E: plain_lut = "a";
			8'h1F: plain_lut = "s";
			8'h20: plain_lut = "d";
			8'h21: plain_lut = "f";
			8'h22: plain_lut = "g";
			8'h23: plain_lut = "h";
			8'h24: plain_lut = "j";
			8'h25: plain_lut = "k";
			8'h26: plain_lut = "l";
			8'h27: plain_lut = 8'h3B;
			8'h28: plain_lut = 8'h27;
			8'h29: plain_lut = 8'h60;
			8'h2B: plain_lut = 8'h5C;
			8'h2C: plain_lut = "z";
			8'h2D: plain_lut = "x";
			8'h2E: plain_lut = "c";
			8'h2F: plain_lut = "v";
			8'h30: plain_lut = "b";
			8'h31: plain_lut = "n";
			8'h32: plain_lut = "m";
			8'h33: plain_lut = 8'h2C;
			8'h34: plain_lut = 8'h2E;
			8'h35: plain_lut = 8'h2F;
			default: plain_lut = pad_lut(code);
		endcase
	endfunction

	function automatic logic [7:0] upper_lut(input logic [7:0] code);
		case (code)
			8'h02: upper_lut = 8'h21;
			8'h03: upper_lut = 8'h40;
			8'h04: upper_lut = 8'h23;
			8'h05: upper_lut = 8'h24;
			8'h06: upper_lut = 8'h25;
			8'h07: upper_lut = 8'h5E;
			8'h08: upper_lut = 8'h26;
			8'h09: upper_lut = 8'h2A;
			8'h0A: upper_lut = 8'h28;
			8'h0B: upper_lut = 8'h29;
			8'h0C: upper_lut = 8'h5F;
			8'h0D: upper_lut = 8'h2B;
			8'h10: upper_lut = "Q";
			8'h11: upper_lut = "W";
			8'h12: upper_lut = "E";
			8'h13: upper_lut = "R";
			8'h14: upper_lut = "T";
			8'h15: upper_lut = "Y";
			8'h16: upper_lut = "U";
			8'h17: upper_lut = "I";
			8'h18: upper_lut = "O";
			8'h19: upper_lut = "P";
			8'h1A: upper_lut = 8'h7B;
			8'h1B: upper_lut = 8'h7D;
			8'h1E: upper_lut = "A";
			8'h1F: upper_lut = "S";
			8'h20: upper_lut = "D";
			8'h21: upper_lut = "F";
			8'h22: upper_lut = "G";
			8'h23: upper_lut = "H";
			8'h24: upper_lut = "J";
			8'h25: upper_lut = "K";
			8'h26: upper_lut = "L";
			8'h27: upper_lut = 8'h3A;
			8'h28: upper_lut = 8'h22;
			8'h29: upper_lut = 8'h7E;
			8'h2B: upper_lut = 8'h7C;
			8'h2C: upper_lut = "Z";
			8'h2D: upper_lut = "X";
			8'h2E: upper_lut = "C";
			8'h2F: upper_lut = "V";
			8'h30: upper_lut = "B";
			8'h31: upper_lut = "N";
			8'h32: upper_lut = "M";
			8'h33: upper_lut = 8'h3C;
			8'h34: upper_lut = 8'h3E;
			8'h35: upper_lut = 8'h3F;
			default: upper_lut = pad_lut(code);
		endcase
	endfunction

	// control codes are the letter minus 0x40
	function automatic logic [7:0] ctrl_lut(input logic [7:0] code);
		case (code)
			8'h10: ctrl_lut = 8'h11;
			8'h11: ctrl_lut = 8'h17;
			8'h12: ctrl_lut = 8'h05;
			8'h13: ctrl_lut = 8'h12;
			8'h14: ctrl_lut = 8'h14;
			8'h15: ctrl_lut = 8'h19;
			8'h16: ctrl_lut = 8'h15;
			8'h17: ctrl_lut = 8'h09;
			8'h18: ctrl_lut = 8'h0F;
			8'h19: ctrl_lut = 8'h10;
			8'h1C: ctrl_lut = 8'h0D;
			8'h1E: ctrl_lut = 8'h01;
			8'h1F: ctrl_lut = 8'h13;
			8'h20: ctrl_lut = 8'h04;
			8'h21: ctrl_lut = 8'h06;
			8'h22: ctrl_lut = 8'h07;
			8'h23: ctrl_lut = 8'h08;
			8'h24: ctrl_lut = 8'h0A;
			8'h25: ctrl_lut = 8'h0B;
			8'h26: ctrl_lut = 8'h0C;
			8'h2B: ctrl_lut = 8'h1C;
			8'h2C: ctrl_lut = 8'h1A;
			8'h2D: ctrl_lut = 8'h18;
			8'h2E: ctrl_lut = 8'h03;
			8'h2F: ctrl_lut = 8'h16;
			8'h30: ctrl_lut = 8'h02;
			8'h31: ctrl_lut = 8'h0E;
			8'h32: ctrl_lut = 8'h0D;
			8'h35: ctrl_lut = 8'hEF;
			8'h9C: ctrl_lut = 8'h0D;
			8'hB5: ctrl_lut = 8'hEF;
			default: ctrl_lut = ext_lut(code);
		endcase
	endfunction

	function automatic mod_t hold_bits(input logic [7:0] code);
		hold_bits = '0;
		case (code)
			8'h1D, 8'h9D: hold_bits[MOD_CTRL] = 1'b1;
			8'h2A, 8'h36: hold_bits[MOD_SHIFT] = 1'b1;
			8'h38, 8'hB8: hold_bits[MOD_ALT] = 1'b1;
			default: hold_bits = '0;
		endcase
	endfunction

	function automatic mod_t lock_bits(input logic [7:0] code);
		lock_bits = '0;
		case (code)
			8'h3A: lock_bits[MOD_CAPS] = 1'b1;
			8'h45: lock_bits[MOD_NUM] = 1'b1;
			8'h46: lock_bits[MOD_SCROLL] = 1'b1;
			default: lock_bits = '0;
		endcase
	endfunction

	// map choice plus caps-lock case swap
	function automatic logic [7:0] translate(input logic [7:0] code, input mod_t mods);
		logic [7:0] c;
		c = mods[MOD_CTRL] ? ctrl_lut(code) :
			mods[MOD_SHIFT] ? upper_lut(code) : plain_lut(code);
		if (mods[MOD_CAPS]) begin
			if (c >= 8'h61 && c <= 8'h7A)
				c = c - 8'h20;
			else if (c >= 8'h41 && c <= 8'h5A)
				c = c + 8'h20;
		end
		translate = c;
	endfunction

endpackage

### src/ps2_scancode_to_ascii.sv
// PS/2 set-1 scancode to ASCII decoder.
// Input channel: in_valid / in_ready with scan_byte, one raw scancode byte per request.
// Output channel: out_valid / out_ready with char_code and modifier_flags.
// Every input byte yields exactly one result, in order; char_code 0 means no character.
// modifier_flags: bit0 shift, bit1 ctrl, bit2 alt, bit3 caps, bit4 num, bit5 scroll.
// Result path: an accepted byte goes to the input register, then its result to the
// result register, which drives out_valid; a receiver stall holds it in between.
// Throughput: one byte per cycle while out_ready holds high; mods_q updates per result.
// in_ready stays high while the result register is empty or being taken, so a
// new byte enters in the same cycle a finished result leaves.
// Receiver stall: the result holds steady, one further byte waits in the input
// register, then in_ready drops until out_ready returns.
// Reset clears modifiers, the pending 0xE0 prefix and both valid flags.
module ps2_scancode_to_ascii (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] char_code,
	output logic [5:0] modifier_flags
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	logic [7:0]        char_s2;
	ps2sa_pkg::mod_t   mods_s2;
	ps2sa_pkg::mod_t   mods_q;
	logic              esc_q;

	logic              adv_out;
	logic [7:0]        code;
	logic [7:0]        chr_d;
	ps2sa_pkg::mod_t   mods_d;
	logic              esc_d;

	assign adv_out  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_out;

	always_comb begin
		code   = byte_s1;
		chr_d  = 8'h00;
		mods_d = mods_q;
		esc_d  = esc_q;
		if (byte_s1 == ps2sa_pkg::ESC_PREFIX) begin
			esc_d = 1'b1;
		end else if (byte_s1[7]) begin
			// release: prefixed keys keep bit 7 for the lookup
			code   = esc_q ? byte_s1 : {1'b0, byte_s1[6:0]};
			mods_d = mods_q & ~ps2sa_pkg::hold_bits(code);
			esc_d  = 1'b0;
		end else begin
			code   = esc_q ? (byte_s1 | 8'h80) : byte_s1;
			mods_d = (mods_q | ps2sa_pkg::hold_bits(code)) ^ ps2sa_pkg::lock_bits(code);
			esc_d  = 1'b0;
			chr_d  = ps2sa_pkg::translate(code, mods_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mods_q   <= '0;
			esc_q    <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_out) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					mods_q <= mods_d;
					esc_q  <= esc_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= scan_byte;
		if (adv_out && valid_s1) begin
			char_s2 <= chr_d;
			mods_s2 <= mods_d;
		end
	end

	assign out_valid      = valid_s2;
	assign char_code      = char_s2;
	assign modifier_flags = mods_s2;

endmodule

### src/ps2sa_checker.sv
`include "ps2_scancode_to_ascii_assert.svh"

module ps2sa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] char_code,
	input logic [5:0] modifier_flags
);

	logic stall;
	logic lower_out;
	logic shift_on;
	logic ctrl_on;
	logic caps_on;

	assign stall     = out_valid && !out_ready;
	assign lower_out = (char_code >= 8'h61) && (char_code <= 8'h7A);
	assign shift_on  = modifier_flags[ps2sa_pkg::MOD_SHIFT];
	assign ctrl_on   = modifier_flags[ps2sa_pkg::MOD_CTRL];
	assign caps_on   = modifier_flags[ps2sa_pkg::MOD_CAPS];

	`PS2SA_NEXT(a_stall_keeps_valid, stall, out_valid)
	`PS2SA_NEXT(a_stall_keeps_result, stall, $stable(char_code) && $stable(modifier_flags))
	// caps lock alone turns every letter upper case
	`PS2SA_CHECK(a_caps_no_lower, out_valid && caps_on && !shift_on && !ctrl_on, !lower_out)
	// shift without caps never gives a lower-case letter
	`PS2SA_CHECK(a_shift_no_lower, out_valid && shift_on && !caps_on && !ctrl_on, !lower_out)
	// ctrl map holds only control codes and special keys
	`PS2SA_CHECK(a_ctrl_range, out_valid && ctrl_on, char_code <= 8'h1C || char_code >= 8'hE0)

endmodule

bind ps2_scancode_to_ascii ps2sa_checker u_ps2sa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.char_code      (char_code),
	.modifier_flags (modifier_flags)
);
